// ===== sv/bid_pkg.sv =====
// Shared types and constants for the backlight inactivity dimmer.
// Holds the input, result, snapshot and register word layouts; no dependencies.
package bid_pkg;

  localparam logic [1:0] LVL_ACTIVE = 2'd0;
  localparam logic [1:0] LVL_DIM    = 2'd1;
  localparam logic [1:0] LVL_OFF    = 2'd2;

  localparam logic [6:0] FULL_PERCENT    = 7'd100;
  localparam logic [7:0] DIM_MAX_PERCENT = 8'd99;

  localparam logic [2:0] SCR_INFO      = 3'd1;
  localparam logic [2:0] SCR_RAW       = 3'd2;
  localparam logic [2:0] SCR_ALERT     = 3'd3;
  localparam logic [2:0] SCR_PROVISION = 3'd4;

  localparam logic [1:0] WIFI_AP_SETUP = 2'd3;

  localparam logic CMD_SNAPSHOT = 1'b0;
  localparam logic CMD_BUTTON   = 1'b1;

  localparam logic [2:0] CFG_DIMMING_ENABLED = 3'd0;
  localparam logic [2:0] CFG_DIM_TIMEOUT_MS  = 3'd1;
  localparam logic [2:0] CFG_OFF_TIMEOUT_MS  = 3'd2;
  localparam logic [2:0] CFG_DIM_PERCENT     = 3'd3;
  localparam logic [2:0] CFG_ALERT_KEEPS_ON  = 3'd4;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic [2:0]  screen;
    logic [2:0]  alert_code;
    logic [2:0]  dismissed_alert;
    logic        telemetry_valid;
    logic [3:0]  dryer_phase;
    logic        link_is_up;
    logic [1:0]  wifi_status;
    logic        broker_connected;
  } bid_in_t;

  typedef struct packed {
    logic [1:0] display_level;
    logic [6:0] backlight_percent;
    logic       press_acts;
  } bid_out_t;

  typedef struct packed {
    logic [2:0] screen;
    logic       telemetry_valid;
    logic [3:0] phase;
    logic [2:0] alert;
    logic       link;
    logic [1:0] wifi;
    logic       broker;
  } bid_snap_t;

  typedef struct packed {
    logic        dimming_enabled;
    logic [23:0] dim_timeout_ms;
    logic [23:0] off_timeout_ms;
    logic [7:0]  dim_percent;
    logic        alert_keeps_on;
  } bid_cfg_t;

endpackage

// ===== sv/bid_event.sv =====
// Activity detector: compares a status snapshot with the stored previous one.
// Depends on bid_pkg for the snapshot layout and screen codes.
module bid_event (
  input  logic              seeded,
  input  bid_pkg::bid_snap_t prev,
  input  bid_pkg::bid_snap_t cur,
  output logic              event_hit
);
  import bid_pkg::*;

  logic prev_override;
  logic cur_override;
  logic screen_evt;
  logic telem_evt;
  logic link_evt;

  always_comb begin
    prev_override = prev.screen inside {SCR_INFO, SCR_RAW};
    cur_override  = cur.screen inside {SCR_INFO, SCR_RAW};
    // Leaving an override screen for a normal screen is not user activity.
    screen_evt = (cur.screen != prev.screen) &&
                 !(prev_override && !cur_override && (cur.screen != SCR_ALERT));
    telem_evt  = (cur.telemetry_valid != prev.telemetry_valid) ||
                 (cur.telemetry_valid && (cur.phase != prev.phase));
    link_evt   = (cur.alert != prev.alert) || (cur.link != prev.link) ||
                 (cur.wifi != prev.wifi) || (cur.broker != prev.broker);
    event_hit  = seeded && (screen_evt || telem_evt || link_evt);
  end

endmodule

// ===== sv/bid_level.sv =====
// Level selection: idle-time thresholds, alert and provisioning floors, percent.
// Depends on bid_pkg for the register layout and level codes.
module bid_level (
  input  bid_pkg::bid_cfg_t cfg,
  input  logic [31:0]       idle_ms,
  input  logic [2:0]        screen,
  input  logic [2:0]        alert_code,
  input  logic [2:0]        dismissed_alert,
  input  logic [1:0]        wifi_status,
  output logic [1:0]        level,
  output logic [6:0]        percent
);
  import bid_pkg::*;

  logic [1:0] time_lvl;
  logic [1:0] floor_lvl;

  always_comb begin
    time_lvl = LVL_ACTIVE;
    if (cfg.dimming_enabled && (cfg.dim_timeout_ms != '0)) begin
      if (idle_ms >= {8'd0, cfg.dim_timeout_ms}) begin
        time_lvl = LVL_DIM;
      end
      if ((cfg.off_timeout_ms != '0) && (idle_ms >= {8'd0, cfg.off_timeout_ms})) begin
        time_lvl = LVL_OFF;
      end
    end

    floor_lvl = LVL_OFF;
    if (alert_code != '0) begin
      if ((dismissed_alert != alert_code) && cfg.alert_keeps_on) begin
        floor_lvl = LVL_ACTIVE;
      end else begin
        floor_lvl = LVL_DIM;
      end
    end
    if ((floor_lvl != LVL_ACTIVE) &&
        ((wifi_status == WIFI_AP_SETUP) || (screen == SCR_PROVISION))) begin
      floor_lvl = LVL_DIM;
    end

    level = (time_lvl > floor_lvl) ? floor_lvl : time_lvl;

    case (level)
      LVL_ACTIVE: percent = FULL_PERCENT;
      LVL_DIM: begin
        if (cfg.dim_percent == '0) begin
          percent = 7'd1;
        end else if (cfg.dim_percent > DIM_MAX_PERCENT) begin
          percent = DIM_MAX_PERCENT[6:0];
        end else begin
          percent = cfg.dim_percent[6:0];
        end
      end
      default: percent = 7'd0;
    endcase
  end

endmodule

// ===== sv/backlight_inactivity_dimmer_unit.sv =====
// Top level of the backlight inactivity dimmer: input register, state, result register.
// Depends on bid_pkg, bid_event and bid_level.
//
// Each word is either a status snapshot or a button press and yields exactly one result
// word. A word is taken into an input register, evaluated against the stored snapshot,
// idle timer and level, and moved into the result register together with the
// state update. The block accepts one word per clock cycle while the output side is not
// stalled, the state loop (event detect, 32-bit idle subtraction and threshold compares)
// setting that rate. The user must write registers through the cfg port only while no
// word is in flight; the block itself does not enforce this.
module backlight_inactivity_dimmer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bid_pkg::bid_in_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output bid_pkg::bid_out_t out_word,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_wdata
);
  import bid_pkg::*;

  bid_cfg_t   cfg_r;
  bid_in_t    s1_word_r;
  logic       s1_valid_r;
  bid_out_t   out_word_r;
  logic       out_valid_r;

  logic [31:0] last_r;
  logic [31:0] last_nxt;
  logic [1:0]  level_r;
  logic [1:0]  level_nxt;
  logic        seeded_r;
  logic        seeded_nxt;
  bid_snap_t   prev_r;
  bid_snap_t   prev_nxt;
  bid_out_t    res_nxt;

  bid_snap_t   cur_snap;
  logic        event_hit;
  logic [31:0] idle_ms;
  logic [1:0]  snap_level;
  logic [6:0]  snap_percent;
  logic        in_fire;
  logic        s1_go;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    cur_snap.screen          = s1_word_r.screen;
    cur_snap.telemetry_valid = s1_word_r.telemetry_valid;
    cur_snap.phase           = s1_word_r.dryer_phase;
    cur_snap.alert           = s1_word_r.alert_code;
    cur_snap.link            = s1_word_r.link_is_up;
    cur_snap.wifi            = s1_word_r.wifi_status;
    cur_snap.broker          = s1_word_r.broker_connected;
  end

  bid_event u_event (
    .seeded    (seeded_r),
    .prev      (prev_r),
    .cur       (cur_snap),
    .event_hit (event_hit)
  );

  assign idle_ms = event_hit ? 32'd0 : (s1_word_r.now_ms - last_r);

  bid_level u_level (
    .cfg             (cfg_r),
    .idle_ms         (idle_ms),
    .screen          (s1_word_r.screen),
    .alert_code      (s1_word_r.alert_code),
    .dismissed_alert (s1_word_r.dismissed_alert),
    .wifi_status     (s1_word_r.wifi_status),
    .level           (snap_level),
    .percent         (snap_percent)
  );

  always_comb begin
    if (s1_word_r.command == CMD_BUTTON) begin
      last_nxt                  = s1_word_r.now_ms;
      level_nxt                 = LVL_ACTIVE;
      seeded_nxt                = seeded_r;
      prev_nxt                  = prev_r;
      res_nxt.display_level     = LVL_ACTIVE;
      res_nxt.backlight_percent = FULL_PERCENT;
      res_nxt.press_acts        = (level_r != LVL_OFF);
    end else begin
      last_nxt                  = event_hit ? s1_word_r.now_ms : last_r;
      level_nxt                 = snap_level;
      seeded_nxt                = 1'b1;
      prev_nxt                  = cur_snap;
      res_nxt.display_level     = snap_level;
      res_nxt.backlight_percent = snap_percent;
      res_nxt.press_acts        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dimming_enabled <= 1'b1;
      cfg_r.dim_timeout_ms  <= 24'd30000;
      cfg_r.off_timeout_ms  <= 24'd300000;
      cfg_r.dim_percent     <= 8'd20;
      cfg_r.alert_keeps_on  <= 1'b1;
      s1_valid_r            <= 1'b0;
      out_valid_r           <= 1'b0;
      last_r                <= '0;
      level_r               <= LVL_ACTIVE;
      seeded_r              <= 1'b0;
      prev_r                <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIMMING_ENABLED: cfg_r.dimming_enabled <= cfg_wdata[0];
          CFG_DIM_TIMEOUT_MS:  cfg_r.dim_timeout_ms  <= cfg_wdata;
          CFG_OFF_TIMEOUT_MS:  cfg_r.off_timeout_ms  <= cfg_wdata;
          CFG_DIM_PERCENT:     cfg_r.dim_percent     <= cfg_wdata[7:0];
          CFG_ALERT_KEEPS_ON:  cfg_r.alert_keeps_on  <= cfg_wdata[0];
          default: ;
        endcase
      end
      s1_valid_r  <= in_fire || (s1_valid_r && !s1_go);
      out_valid_r <= s1_go || (out_valid_r && !out_ready);
      if (s1_go) begin
        last_r   <= last_nxt;
        level_r  <= level_nxt;
        seeded_r <= seeded_nxt;
        prev_r   <= prev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_word;
    end
    if (s1_go) begin
      out_word_r <= res_nxt;
    end
  end

  a_press_wakes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_word_r.command == CMD_BUTTON) |=> level_r == LVL_ACTIVE)
    else $error("button press did not leave the display active");

  a_snapshot_seeds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_word_r.command == CMD_SNAPSHOT) |=> seeded_r)
    else $error("snapshot did not seed the stored snapshot");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r && (out_word_r.display_level == level_r))
    else $error("result word does not match the stored level");

  a_level_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.display_level != 2'd3)
    else $error("illegal display level in result word");

  a_press_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.press_acts |->
      (out_word_r.display_level == LVL_ACTIVE) &&
      (out_word_r.backlight_percent == FULL_PERCENT))
    else $error("press result is not active at full brightness");

endmodule

// ===== tb/sv/bid_dimmer_sb_pkg.sv =====
// Scoreboard for the backlight inactivity dimmer testbench: a cycle-free model of the
// idle timer, snapshot compare and level floors, plus the queue of expected result words.
// Depends on bid_pkg for the word, snapshot and register layouts.
package bid_dimmer_sb_pkg;
  import bid_pkg::*;

  class dimmer_scoreboard;
    bid_cfg_t    regs;
    logic [31:0] event_time_ms;
    logic [1:0]  level;
    logic        seeded;
    bid_snap_t   prev;
    bid_out_t    expected_q[$];
    int          errors;

    function new();
      regs = '{dimming_enabled: 1'b1, dim_timeout_ms: 24'd30000, off_timeout_ms: 24'd300000,
               dim_percent: 8'd20, alert_keeps_on: 1'b1};
      event_time_ms = '0;
      level = LVL_ACTIVE;
      seeded = 1'b0;
      prev = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
        CFG_DIMMING_ENABLED: regs.dimming_enabled = data[0];
        CFG_DIM_TIMEOUT_MS:  regs.dim_timeout_ms = data;
        CFG_OFF_TIMEOUT_MS:  regs.off_timeout_ms = data;
        CFG_DIM_PERCENT:     regs.dim_percent = data[7:0];
        CFG_ALERT_KEEPS_ON:  regs.alert_keeps_on = data[0];
        default: ;
      endcase
    endfunction

    function logic is_override(logic [2:0] s);
      return s == SCR_INFO || s == SCR_RAW;
    endfunction

    function logic [6:0] percent_of(logic [1:0] lvl);
      if (lvl == LVL_ACTIVE) return FULL_PERCENT;
      if (lvl == LVL_DIM) begin
        if (regs.dim_percent == 8'd0) return 7'd1;
        if (regs.dim_percent > DIM_MAX_PERCENT) return DIM_MAX_PERCENT[6:0];
        return regs.dim_percent[6:0];
      end
      return 7'd0;
    endfunction

    function void note_input(bid_in_t w);
      bid_out_t    r;
      bid_snap_t   cur;
      logic        activity;
      logic [31:0] idle_ms;
      logic [1:0]  lvl;
      logic [1:0]  limit_lvl;
      r = '0;
      if (w.command == CMD_BUTTON) begin
        r.press_acts = (level != LVL_OFF);
        event_time_ms = w.now_ms;
        level = LVL_ACTIVE;
        r.display_level = LVL_ACTIVE;
        r.backlight_percent = FULL_PERCENT;
      end else begin
        cur = '{screen: w.screen, telemetry_valid: w.telemetry_valid, phase: w.dryer_phase,
                alert: w.alert_code, link: w.link_is_up, wifi: w.wifi_status,
                broker: w.broker_connected};
        activity = 1'b0;
        if (seeded) begin
          // Leaving an info or raw screen for a plain screen is not user activity.
          if (cur.screen != prev.screen && !(is_override(prev.screen) &&
              !is_override(cur.screen) && cur.screen != SCR_ALERT))
            activity = 1'b1;
          if (cur.telemetry_valid != prev.telemetry_valid ||
              (cur.telemetry_valid && cur.phase != prev.phase))
            activity = 1'b1;
          if (cur.alert != prev.alert || cur.link != prev.link ||
              cur.wifi != prev.wifi || cur.broker != prev.broker)
            activity = 1'b1;
        end
        seeded = 1'b1;
        prev = cur;
        if (activity) event_time_ms = w.now_ms;
        lvl = LVL_ACTIVE;
        if (regs.dimming_enabled && regs.dim_timeout_ms != 24'd0) begin
          idle_ms = w.now_ms - event_time_ms;
          if (idle_ms >= {8'd0, regs.dim_timeout_ms}) lvl = LVL_DIM;
          if (regs.off_timeout_ms != 24'd0 && idle_ms >= {8'd0, regs.off_timeout_ms})
            lvl = LVL_OFF;
        end
        limit_lvl = LVL_OFF;
        if (cur.alert != 3'd0) begin
          if (w.dismissed_alert != cur.alert && regs.alert_keeps_on) limit_lvl = LVL_ACTIVE;
          else limit_lvl = LVL_DIM;
        end
        if (limit_lvl != LVL_ACTIVE && (cur.wifi == WIFI_AP_SETUP || cur.screen == SCR_PROVISION))
          limit_lvl = LVL_DIM;
        if (lvl > limit_lvl) lvl = limit_lvl;
        level = lvl;
        r.display_level = lvl;
        r.backlight_percent = percent_of(lvl);
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(bid_out_t got);
      bid_out_t want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.display_level !== want.display_level) begin
        $error("display_level: expected %0d, actual %0d", want.display_level, got.display_level);
        errors++;
      end
      if (got.backlight_percent !== want.backlight_percent) begin
        $error("backlight_percent: expected %0d, actual %0d", want.backlight_percent,
               got.backlight_percent);
        errors++;
      end
      if (got.press_acts !== want.press_acts) begin
        $error("press_acts: expected %0d, actual %0d", want.press_acts, got.press_acts);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
// Top-level testbench for backlight_inactivity_dimmer_unit: directed and random words under
// several register settings and idle patterns, checked against the scoreboard.
// Depends on bid_pkg, bid_dimmer_sb_pkg and the RTL of the unit.
module tb;
  import bid_pkg::*;
  import bid_dimmer_sb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 235;
  localparam int NUM_SETTINGS = 8;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  bid_in_t     in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bid_out_t    out_word;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_DIMMING_ENABLED;
  logic [23:0] cfg_wdata = '0;

  dimmer_scoreboard sb;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          rx_hold_req;
  int          stall_cycles;
  bid_cfg_t    act_cfg;
  bid_cfg_t    settings[NUM_SETTINGS];
  bid_snap_t   gen_snap;
  logic [2:0]  gen_dismissed;
  logic [31:0] time_ms;

  backlight_inactivity_dimmer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_word);
      if (out_valid && out_ready) sb.check_result(out_word);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("backlight_inactivity_dimmer_unit test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // The receiver either stalls at random or, on request, holds off for a long stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic bid_in_t snap_word(logic [31:0] now, logic [2:0] scr, logic [2:0] al,
                                        logic [2:0] dis, logic val, logic [3:0] ph,
                                        logic lnk, logic [1:0] wf, logic brk);
    bid_in_t w;
    w = '{command: CMD_SNAPSHOT, now_ms: now, screen: scr, alert_code: al,
          dismissed_alert: dis, telemetry_valid: val, dryer_phase: ph, link_is_up: lnk,
          wifi_status: wf, broker_connected: brk};
    return w;
  endfunction

  function automatic bid_in_t press_word(logic [31:0] now);
    bid_in_t w;
    w = '0;
    w.command = CMD_BUTTON;
    w.now_ms = now;
    return w;
  endfunction

  task automatic send_word(bid_in_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic put_reg(logic [2:0] idx, logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic write_settings(bid_cfg_t c);
    put_reg(CFG_DIMMING_ENABLED, {23'd0, c.dimming_enabled});
    put_reg(CFG_DIM_TIMEOUT_MS, c.dim_timeout_ms);
    put_reg(CFG_OFF_TIMEOUT_MS, c.off_timeout_ms);
    put_reg(CFG_DIM_PERCENT, {16'd0, c.dim_percent});
    put_reg(CFG_ALERT_KEEPS_ON, {23'd0, c.alert_keeps_on});
    cfg_we <= 1'b0;
    act_cfg = c;
  endtask

  task automatic drain();
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly steady snapshots with a slowly moving clock, so the idle timer crosses both
  // thresholds; occasional single-field changes, button presses and random noise.
  task automatic make_word(output bid_in_t w);
    int unsigned span_dim;
    int unsigned span_off;
    int unsigned r;
    logic [63:0] noise;
    span_dim = (act_cfg.dim_timeout_ms != 24'd0) ? act_cfg.dim_timeout_ms : 5000;
    span_off = (act_cfg.off_timeout_ms != 24'd0) ? act_cfg.off_timeout_ms : span_dim * 4;
    r = $urandom_range(99);
    if (r < 45) time_ms += $urandom_range(span_dim / 4);
    else if (r < 65) time_ms += $urandom_range(span_dim - span_dim / 8, span_dim + span_dim / 8);
    else if (r < 85) time_ms += $urandom_range(span_off - span_off / 8, span_off + span_off / 8);
    else if (r < 93) time_ms += $urandom();
    r = $urandom_range(99);
    noise = {$urandom(), $urandom()};
    if (r < 10) begin
      w = noise[$bits(bid_in_t)-1:0];
      w.command = CMD_BUTTON;
      w.now_ms = time_ms;
    end else if (r < 15) begin
      w = noise[$bits(bid_in_t)-1:0];
      w.command = CMD_SNAPSHOT;
    end else begin
      if (r < 32) begin
        case ($urandom_range(6))
          0: gen_snap.screen = 3'($urandom_range(7));
          1: gen_snap.telemetry_valid = ~gen_snap.telemetry_valid;
          2: gen_snap.phase = 4'($urandom_range(15));
          3: gen_snap.alert = 3'($urandom_range(7));
          4: gen_snap.link = ~gen_snap.link;
          5: gen_snap.wifi = 2'($urandom_range(3));
          default: gen_snap.broker = ~gen_snap.broker;
        endcase
      end
      if ($urandom_range(5) == 0)
        gen_dismissed = $urandom_range(1) ? gen_snap.alert : 3'($urandom_range(7));
      w = snap_word(time_ms, gen_snap.screen, gen_snap.alert, gen_dismissed,
                    gen_snap.telemetry_valid, gen_snap.phase, gen_snap.link,
                    gen_snap.wifi, gen_snap.broker);
    end
  endtask

  task automatic run_random(int count, bit with_hold);
    bid_in_t w;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 40) rx_hold_req = 1'b1;
      make_word(w);
      send_word(w);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    bid_in_t plan[$];
    sb = new();
    tx_idle_pct = 30;
    rx_idle_pct = 82;
    rx_hold_req = 1'b0;
    act_cfg = sb.regs;
    gen_snap = '0;
    gen_dismissed = '0;
    time_ms = '0;
    settings[0] = '{1'b1, 24'd30000, 24'd300000, 8'd20, 1'b1};
    settings[1] = '{1'b1, 24'd1000, 24'd5000, 8'd0, 1'b0};
    settings[2] = '{1'b1, 24'hFFFFFF, 24'hFFFFFF, 8'd255, 1'b1};
    settings[3] = '{1'b0, 24'd500, 24'd2000, 8'd99, 1'b1};
    settings[4] = '{1'b1, 24'd0, 24'd1000, 8'd100, 1'b0};
    settings[5] = '{1'b1, 24'd3000, 24'd0, 8'd1, 1'b1};
    settings[6] = '{1'b1, 24'd2000, 24'd1000, 8'd50, 1'b0};
    settings[7] = '{1'($urandom_range(1)), 24'($urandom_range(20000)),
                    24'($urandom_range(100000)), 8'($urandom_range(255)),
                    1'($urandom_range(1))};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: seeding, thresholds, press while off and lit, screen rules,
    // telemetry rules, alert and provisioning floors, time wrap and field extremes.
    plan.push_back(snap_word(32'd40000, 3'd0, 3'd0, 3'd0, 1'b0, 4'd0, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd400000, 3'd0, 3'd0, 3'd0, 1'b0, 4'd0, 1'b0, 2'd0, 1'b0));
    plan.push_back(press_word(32'd400001));
    plan.push_back(press_word(32'd400002));
    plan.push_back(snap_word(32'd500000, SCR_INFO, 3'd0, 3'd0, 1'b0, 4'd0, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd600000, 3'd0, 3'd0, 3'd0, 1'b0, 4'd0, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd600001, SCR_RAW, 3'd0, 3'd0, 1'b0, 4'd0, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd700000, SCR_ALERT, 3'd0, 3'd0, 1'b0, 4'd0, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd700001, SCR_RAW, 3'd0, 3'd0, 1'b0, 4'd0, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd1100000, 3'd5, 3'd0, 3'd0, 1'b0, 4'd0, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd1100001, 3'd5, 3'd0, 3'd0, 1'b0, 4'd9, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd1100002, 3'd5, 3'd0, 3'd0, 1'b1, 4'd9, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd1100003, 3'd5, 3'd0, 3'd0, 1'b1, 4'd10, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd1100004, 3'd5, 3'd2, 3'd0, 1'b1, 4'd10, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd2000000, 3'd5, 3'd2, 3'd0, 1'b1, 4'd10, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd2000001, 3'd5, 3'd2, 3'd2, 1'b1, 4'd10, 1'b0, 2'd0, 1'b0));
    plan.push_back(snap_word(32'd2000002, 3'd5, 3'd0, 3'd2, 1'b1, 4'd10, 1'b1,
                             WIFI_AP_SETUP, 1'b0));
    plan.push_back(snap_word(32'd3000000, 3'd5, 3'd0, 3'd2, 1'b1, 4'd10, 1'b1,
                             WIFI_AP_SETUP, 1'b0));
    plan.push_back(snap_word(32'd3000001, SCR_PROVISION, 3'd0, 3'd0, 1'b1, 4'd10, 1'b1,
                             2'd0, 1'b1));
    plan.push_back(snap_word(32'd4000000, SCR_PROVISION, 3'd0, 3'd0, 1'b1, 4'd10, 1'b1,
                             2'd0, 1'b1));
    plan.push_back(snap_word(32'hFFFFFF00, 3'd0, 3'd0, 3'd0, 1'b1, 4'd10, 1'b1, 2'd0, 1'b1));
    plan.push_back(snap_word(32'h00001000, 3'd0, 3'd0, 3'd0, 1'b1, 4'd10, 1'b1, 2'd0, 1'b1));
    plan.push_back(snap_word(32'hFFFFFFFF, 3'd7, 3'd7, 3'd7, 1'b1, 4'd15, 1'b1,
                             WIFI_AP_SETUP, 1'b1));
    plan.push_back(press_word(32'd0));
    foreach (plan[i]) send_word(plan[i]);
    in_valid <= 1'b0;
    drain();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p < 3) begin
        tx_idle_pct = 30;
        rx_idle_pct = 82;
      end else if (p < 6) begin
        tx_idle_pct = 82;
        rx_idle_pct = 30;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_settings(settings[p]);
      run_random(PHASE_WORDS, p == 6);
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("backlight_inactivity_dimmer_unit test passed");
    end else begin
      $display("backlight_inactivity_dimmer_unit test failed");
    end
    $finish;
  end

endmodule
